// ===== rtl/gqvg_pkg.sv =====
// gqvg_pkg: shared types, constants and control store for the glyph quad generator
// used by gqvg_div and glyph_quad_vertex_generator; no dependencies
package gqvg_pkg;

  // character codes
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChBackslash = 8'd92;
  localparam logic [7:0] ChLetterN   = 8'd110;

  // configuration register indexes
  localparam logic [1:0] RegGlyphWidth  = 2'd0;
  localparam logic [1:0] RegGlyphHeight = 2'd1;
  localparam logic [1:0] RegGridColumns = 2'd2;
  localparam logic [1:0] RegGridRows    = 2'd3;

  // register reset values
  localparam logic [7:0] GlyphWidthRst  = 8'd8;
  localparam logic [7:0] GlyphHeightRst = 8'd16;
  localparam logic [8:0] GridColumnsRst = 9'd16;
  localparam logic [8:0] GridRowsRst    = 9'd16;

  // texture coordinate 1.0 in unsigned 1.16
  localparam logic [16:0] TexOne = 17'h10000;

  // divider step counts
  localparam logic [4:0] DivStepsChar = 5'd8;
  localparam logic [4:0] DivStepsFrac = 5'd16;

  // divider request and status
  typedef struct packed {
    logic       start;
    logic [8:0] rem_init;
    logic [15:0] dvd_lo;
    logic [8:0] divisor;
    logic [4:0] steps;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic [15:0] quot;
    logic [8:0] rem;
  } div_rsp_t;

  // micro operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_FIRST_X,
    OP_FIRST_Y,
    OP_CLASS,
    OP_DIV_CHAR,
    OP_DIV_WAIT,
    OP_COL_ROW,
    OP_FRAC_START,
    OP_FRAC_LATCH,
    OP_CORNERS,
    OP_EMIT,
    OP_ADVANCE
  } op_e;

  // branch kinds
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_GOTO,
    BR_CTRL
  } br_e;

  // texture coordinate selectors for the fraction steps
  localparam logic [2:0] SelU0 = 3'd0;
  localparam logic [2:0] SelU1 = 3'd1;
  localparam logic [2:0] SelV0 = 3'd2;
  localparam logic [2:0] SelV1 = 3'd3;

  localparam int unsigned UcAw = 5;
  localparam logic [UcAw-1:0] UaIdle = '0;

  typedef struct packed {
    op_e            op;
    logic [2:0]     sel;
    br_e            br;
    logic [UcAw-1:0] tgt;
  } ucode_t;

  // control store: one word per step
  function automatic ucode_t uc_rom(input logic [UcAw-1:0] addr);
    ucode_t w;
    w = '{op: OP_IDLE, sel: 3'd0, br: BR_GOTO, tgt: UaIdle};
    case (addr)
      5'd0:  w = '{op: OP_IDLE,       sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd1:  w = '{op: OP_FIRST_X,    sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd2:  w = '{op: OP_FIRST_Y,    sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd3:  w = '{op: OP_CLASS,      sel: 3'd0,  br: BR_CTRL, tgt: UaIdle};
      5'd4:  w = '{op: OP_DIV_CHAR,   sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd5:  w = '{op: OP_DIV_WAIT,   sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd6:  w = '{op: OP_COL_ROW,    sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd7:  w = '{op: OP_FRAC_START, sel: SelU0, br: BR_NEXT, tgt: UaIdle};
      5'd8:  w = '{op: OP_DIV_WAIT,   sel: SelU0, br: BR_NEXT, tgt: UaIdle};
      5'd9:  w = '{op: OP_FRAC_LATCH, sel: SelU0, br: BR_NEXT, tgt: UaIdle};
      5'd10: w = '{op: OP_FRAC_START, sel: SelU1, br: BR_NEXT, tgt: UaIdle};
      5'd11: w = '{op: OP_DIV_WAIT,   sel: SelU1, br: BR_NEXT, tgt: UaIdle};
      5'd12: w = '{op: OP_FRAC_LATCH, sel: SelU1, br: BR_NEXT, tgt: UaIdle};
      5'd13: w = '{op: OP_FRAC_START, sel: SelV0, br: BR_NEXT, tgt: UaIdle};
      5'd14: w = '{op: OP_DIV_WAIT,   sel: SelV0, br: BR_NEXT, tgt: UaIdle};
      5'd15: w = '{op: OP_FRAC_LATCH, sel: SelV0, br: BR_NEXT, tgt: UaIdle};
      5'd16: w = '{op: OP_FRAC_START, sel: SelV1, br: BR_NEXT, tgt: UaIdle};
      5'd17: w = '{op: OP_DIV_WAIT,   sel: SelV1, br: BR_NEXT, tgt: UaIdle};
      5'd18: w = '{op: OP_FRAC_LATCH, sel: SelV1, br: BR_NEXT, tgt: UaIdle};
      5'd19: w = '{op: OP_CORNERS,    sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd20: w = '{op: OP_EMIT,       sel: 3'd0,  br: BR_NEXT, tgt: UaIdle};
      5'd21: w = '{op: OP_EMIT,       sel: 3'd1,  br: BR_NEXT, tgt: UaIdle};
      5'd22: w = '{op: OP_EMIT,       sel: 3'd2,  br: BR_NEXT, tgt: UaIdle};
      5'd23: w = '{op: OP_EMIT,       sel: 3'd3,  br: BR_NEXT, tgt: UaIdle};
      5'd24: w = '{op: OP_EMIT,       sel: 3'd4,  br: BR_NEXT, tgt: UaIdle};
      5'd25: w = '{op: OP_EMIT,       sel: 3'd5,  br: BR_NEXT, tgt: UaIdle};
      5'd26: w = '{op: OP_ADVANCE,    sel: 3'd0,  br: BR_GOTO, tgt: UaIdle};
      default: w = '{op: OP_IDLE,     sel: 3'd0,  br: BR_GOTO, tgt: UaIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gqvg_div.sv =====
// gqvg_div: bit-serial restoring divider, one quotient bit per cycle
// depends on gqvg_pkg for the request and status structs
module gqvg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gqvg_pkg::div_req_t req_i,
  output gqvg_pkg::div_rsp_t rsp_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [8:0]  rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] shr_q, shr_d;
  logic [9:0]  trial;
  logic [9:0]  diff;
  logic        fits;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem_q, shr_q[15]};
  assign diff  = trial - {1'b0, req_i.divisor};
  assign fits  = trial >= {1'b0, req_i.divisor};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    shr_d  = shr_q;
    if (req_i.start) begin
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      quot_d = '0;
      shr_d  = req_i.dvd_lo;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 5'd1;
      rem_d  = fits ? diff[8:0] : trial[8:0];
      quot_d = {quot_q[14:0], fits};
      shr_d  = {shr_q[14:0], 1'b0};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    shr_q  <= shr_d;
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/glyph_quad_vertex_generator.sv =====
// glyph_quad_vertex_generator: text bytes in, six textured quad vertices out per glyph
// depends on gqvg_pkg and gqvg_div
//
//   port group  dir  contents
//   s_axis      in   tdata: char_code, start_col, start_row, fg_color, bg_color
//                    tuser: first_of_text
//   m_axis      out  tdata: pos_x, pos_y, tex_u, tex_v, vert_fg, vert_bg
//                    tlast: last_vertex, tuser: out_of_grid
//   cfg         in   write enable, register index, 9-bit data
//
// a control byte (newline, backslash, escaped byte) passes the first-x, first-y and class steps and returns to idle
// a printable byte waits on the shared bit-serial divider: an 8-bit quotient for
// column and row, then a 16-bit quotient for each of u0, u1, v0, v1
// a stalled output holds the sequencer on the current vertex; the next byte
// is taken while the sixth vertex still waits in the output register
// reset clears pen, escape flag, sequencer and output valid and loads the register defaults
module glyph_quad_vertex_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // text bytes
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // char_code, start_col, start_row, fg_color, bg_color
  input  logic         s_axis_tuser,  // first_of_text
  // vertices
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // pos_x, pos_y, tex_u, tex_v, vert_fg, vert_bg, zero pad
  output logic         m_axis_tlast,  // last_vertex
  output logic         m_axis_tuser,  // out_of_grid
  // configuration
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [8:0]   cfg_wdata_i
);

  localparam int unsigned Aw = gqvg_pkg::UcAw;

  gqvg_pkg::ucode_t   uw;
  gqvg_pkg::div_req_t div_req;
  gqvg_pkg::div_rsp_t div_rsp;

  logic [Aw-1:0] upc_q, upc_d;

  // configuration registers
  logic [7:0] gw_q, gh_q;
  logic [8:0] cols_q, rows_q;
  logic [8:0] cols_eff, rows_eff;

  // latched input item
  logic [7:0]  ch_q, scol_q, srow_q;
  logic        first_q;
  logic [31:0] fg_q, bg_q;

  // pen state
  logic [15:0] pen_x_q, pen_x_d;
  logic [15:0] pen_y_q, pen_y_d;
  logic [15:0] ls_q, ls_d;
  logic        esc_q, esc_d;

  // glyph working values
  logic [7:0]  col_q, row_q;
  logic        oog_q;
  logic [16:0] u0_q, u1_q, v0_q, v1_q;
  logic [15:0] x1_q, y1_q;

  // output register
  logic         ovalid_q;
  logic [129:0] odata_q;
  logic         olast_q, ooog_q;

  logic        in_acc, out_free, step_ok, ctrl_byte, is_nl_step, emit_go;
  logic [15:0] prod;
  logic [7:0]  mul_a, mul_b;
  logic [16:0] y_down, x_right, y_lower;
  logic [8:0]  frac_k, frac_d;
  logic [16:0] frac_res;
  logic [15:0] ex, ey;
  logic [16:0] eu, ev;

  assign uw = gqvg_pkg::uc_rom(upc_q);

  // zero columns or rows count as one
  assign cols_eff = (cols_q == '0) ? 9'd1 : cols_q;
  assign rows_eff = (rows_q == '0) ? 9'd1 : rows_q;

  assign s_axis_tready = uw.op == gqvg_pkg::OP_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign emit_go       = (uw.op == gqvg_pkg::OP_EMIT) && out_free;

  // byte classes: escaped byte, backslash and newline produce nothing
  assign ctrl_byte = esc_q || (ch_q == gqvg_pkg::ChBackslash) || (ch_q == gqvg_pkg::ChNewline);
  assign is_nl_step = esc_q ? (ch_q == gqvg_pkg::ChLetterN) : (ch_q == gqvg_pkg::ChNewline);

  // shared 8x8 multiplier for the start cell
  assign mul_a = (uw.op == gqvg_pkg::OP_FIRST_Y) ? srow_q : scol_q;
  assign mul_b = (uw.op == gqvg_pkg::OP_FIRST_Y) ? gh_q : gw_q;
  assign prod  = {8'd0, mul_a} * {8'd0, mul_b};

  assign y_down  = {1'b0, pen_y_q} + {9'd0, gh_q};
  assign x_right = {1'b0, pen_x_q} + {9'd0, gw_q};
  assign y_lower = y_down;

  // fraction operands: k * 1.0 / d with k <= d or saturated
  always_comb begin
    case (uw.sel)
      gqvg_pkg::SelU0: begin frac_k = {1'b0, col_q};        frac_d = cols_eff; end
      gqvg_pkg::SelU1: begin frac_k = {1'b0, col_q} + 9'd1; frac_d = cols_eff; end
      gqvg_pkg::SelV0: begin frac_k = {1'b0, row_q};        frac_d = rows_eff; end
      gqvg_pkg::SelV1: begin frac_k = {1'b0, row_q} + 9'd1; frac_d = rows_eff; end
      default:         begin frac_k = '0;                   frac_d = cols_eff; end
    endcase
  end

  assign frac_res = (frac_k >= frac_d) ? gqvg_pkg::TexOne : {1'b0, div_rsp.quot};

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = frac_k;
    div_req.dvd_lo   = '0;
    div_req.divisor  = frac_d;
    div_req.steps    = gqvg_pkg::DivStepsFrac;
    if (uw.op == gqvg_pkg::OP_DIV_CHAR) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.dvd_lo   = {ch_q, 8'd0};
      div_req.divisor  = cols_eff;
      div_req.steps    = gqvg_pkg::DivStepsChar;
    end else if (uw.op == gqvg_pkg::OP_FRAC_START) begin
      div_req.start = 1'b1;
    end else if (uw.op == gqvg_pkg::OP_DIV_WAIT && uw.sel == gqvg_pkg::SelU0) begin
      div_req.divisor = frac_d;
    end
  end

  gqvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer: hold, step or branch
  always_comb begin
    case (uw.op)
      gqvg_pkg::OP_IDLE:     step_ok = in_acc;
      gqvg_pkg::OP_DIV_WAIT: step_ok = !div_rsp.busy;
      gqvg_pkg::OP_EMIT:     step_ok = out_free;
      default:               step_ok = 1'b1;
    endcase
    if (!step_ok) begin
      upc_d = upc_q;
    end else if (uw.br == gqvg_pkg::BR_GOTO || (uw.br == gqvg_pkg::BR_CTRL && ctrl_byte)) begin
      upc_d = uw.tgt;
    end else begin
      upc_d = upc_q + Aw'(1);
    end
  end

  // pen and escape updates
  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    ls_d    = ls_q;
    esc_d   = esc_q;
    case (uw.op)
      gqvg_pkg::OP_FIRST_X: begin
        if (first_q) begin
          ls_d    = prod;
          pen_x_d = prod;
        end
      end
      gqvg_pkg::OP_FIRST_Y: begin
        if (first_q) begin
          pen_y_d = prod;
          esc_d   = 1'b0;
        end
      end
      gqvg_pkg::OP_CLASS: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (ch_q == gqvg_pkg::ChBackslash) begin
          esc_d = 1'b1;
        end
        if (is_nl_step) begin
          pen_x_d = ls_q;
          pen_y_d = y_down[16] ? 16'hFFFF : y_down[15:0];
        end
      end
      gqvg_pkg::OP_ADVANCE: begin
        pen_x_d = x1_q;
      end
      default: begin
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= gqvg_pkg::UaIdle;
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      ls_q     <= '0;
      esc_q    <= 1'b0;
      ovalid_q <= 1'b0;
      gw_q     <= gqvg_pkg::GlyphWidthRst;
      gh_q     <= gqvg_pkg::GlyphHeightRst;
      cols_q   <= gqvg_pkg::GridColumnsRst;
      rows_q   <= gqvg_pkg::GridRowsRst;
    end else begin
      upc_q   <= upc_d;
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      ls_q    <= ls_d;
      esc_q   <= esc_d;
      if (emit_go) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gqvg_pkg::RegGlyphWidth:  gw_q   <= cfg_wdata_i[7:0];
          gqvg_pkg::RegGlyphHeight: gh_q   <= cfg_wdata_i[7:0];
          gqvg_pkg::RegGridColumns: cols_q <= cfg_wdata_i;
          gqvg_pkg::RegGridRows:    rows_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // vertex corner selection
  always_comb begin
    if (uw.sel inside {3'd1, 3'd4, 3'd5}) begin
      ex = x1_q;
      eu = u1_q;
    end else begin
      ex = pen_x_q;
      eu = u0_q;
    end
    if (uw.sel inside {3'd2, 3'd3, 3'd5}) begin
      ey = y1_q;
      ev = v1_q;
    end else begin
      ey = pen_y_q;
      ev = v0_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q    <= s_axis_tdata[7:0];
      scol_q  <= s_axis_tdata[15:8];
      srow_q  <= s_axis_tdata[23:16];
      fg_q    <= s_axis_tdata[55:24];
      bg_q    <= s_axis_tdata[87:56];
      first_q <= s_axis_tuser;
    end
    case (uw.op)
      gqvg_pkg::OP_COL_ROW: begin
        col_q <= div_rsp.rem[7:0];
        row_q <= div_rsp.quot[7:0];
        oog_q <= {1'b0, div_rsp.quot[7:0]} >= rows_eff;
      end
      gqvg_pkg::OP_FRAC_LATCH: begin
        case (uw.sel)
          gqvg_pkg::SelU0: u0_q <= frac_res;
          gqvg_pkg::SelU1: u1_q <= frac_res;
          gqvg_pkg::SelV0: v0_q <= frac_res;
          default:         v1_q <= frac_res;
        endcase
      end
      gqvg_pkg::OP_CORNERS: begin
        x1_q <= x_right[16] ? 16'hFFFF : x_right[15:0];
        y1_q <= y_lower[16] ? 16'hFFFF : y_lower[15:0];
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      odata_q <= {bg_q, fg_q, ev, eu, ey, ex};
      olast_q <= uw.sel == 3'd5;
      ooog_q  <= oog_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, odata_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ooog_q;

endmodule

// ===== sim/testbench.sv =====
// testbench for glyph_quad_vertex_generator: text words in, six quad vertices per glyph out
// self-checking against an in-bench model of pen, escape and atlas math; needs gqvg_pkg
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned HoldCycles   = 700;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainCycles  = 150;

  // one vertex as it leaves the block
  typedef struct packed {
    logic        last;
    logic        oog;
    logic [31:0] bg;
    logic [31:0] fg;
    logic [16:0] v;
    logic [16:0] u;
    logic [15:0] y;
    logic [15:0] x;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;  // char_code, start_col, start_row, fg_color, bg_color
  logic         s_axis_tuser = 1'b0;  // first_of_text
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;  // pos_x, pos_y, tex_u, tex_v, vert_fg, vert_bg, zero pad
  logic         m_axis_tlast;  // last_vertex
  logic         m_axis_tuser;  // out_of_grid
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = gqvg_pkg::RegGlyphWidth;
  logic [8:0]   cfg_wdata_i = '0;

  glyph_quad_vertex_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model copy of registers and pen state
  logic [7:0]  glyph_w = gqvg_pkg::GlyphWidthRst;
  logic [7:0]  glyph_h = gqvg_pkg::GlyphHeightRst;
  logic [8:0]  atlas_cols = gqvg_pkg::GridColumnsRst;
  logic [8:0]  atlas_rows = gqvg_pkg::GridRowsRst;
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  logic [15:0] margin_x = '0;
  logic        esc_pending = 1'b0;

  // expected vertices in a ring, written by the sender, read by the checker
  vertex_t     exp_ring [256];
  logic [7:0]  exp_wr = '0;
  logic [7:0]  exp_rd = '0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          tx_gaps_on = 1'b1;

  // receiver stall pattern and long hold-off
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned pat_age = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  function automatic logic [15:0] clamp_px(input int unsigned val);
    return (val > 65535) ? 16'hFFFF : val[15:0];
  endfunction

  // floor(n * 1.0 / d) in unsigned 1.16, clamped to 1.0
  function automatic logic [16:0] atlas_frac(input int unsigned n, input int unsigned d);
    longint unsigned q;
    q = (longint'(n) << 16) / d;
    return (q > 65536) ? gqvg_pkg::TexOne : q[16:0];
  endfunction

  task automatic line_feed();
    int unsigned y;
    y = pen_y;
    y = y + glyph_h;
    pen_x = margin_x;
    pen_y = clamp_px(y);
  endtask

  task automatic push_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [16:0] u, input logic [16:0] v,
                             input logic [31:0] fg, input logic [31:0] bg,
                             input logic oog, input logic last);
    vertex_t vx;
    vx = '{last: last, oog: oog, bg: bg, fg: fg, v: v, u: u, y: y, x: x};
    exp_ring[exp_wr] = vx;
    exp_wr = exp_wr + 8'd1;
  endtask

  // expected vertices for one accepted text word
  task automatic predict_glyph_vertices(input logic first, input logic [7:0] code,
                                        input logic [7:0] scol, input logic [7:0] srow,
                                        input logic [31:0] fg, input logic [31:0] bg);
    int unsigned cols, rows, col, row, a, b;
    logic [15:0] x0, y0, x1, y1;
    logic [16:0] u0, u1, v0, v1;
    logic        oog;
    if (first) begin
      a = scol;
      b = srow;
      esc_pending = 1'b0;
      margin_x = clamp_px(a * glyph_w);
      pen_x = margin_x;
      pen_y = clamp_px(b * glyph_h);
    end
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (code == gqvg_pkg::ChLetterN) line_feed();
    end else if (code == gqvg_pkg::ChBackslash) begin
      esc_pending = 1'b1;
    end else if (code == gqvg_pkg::ChNewline) begin
      line_feed();
    end else begin
      cols = (atlas_cols == 0) ? 1 : atlas_cols;
      rows = (atlas_rows == 0) ? 1 : atlas_rows;
      col = code % cols;
      row = code / cols;
      oog = (row >= rows);
      u0 = atlas_frac(col, cols);
      u1 = atlas_frac(col + 1, cols);
      v0 = atlas_frac(row, rows);
      v1 = atlas_frac(row + 1, rows);
      a = pen_x;
      b = pen_y;
      x0 = pen_x;
      y0 = pen_y;
      x1 = clamp_px(a + glyph_w);
      y1 = clamp_px(b + glyph_h);
      push_vertex(x0, y0, u0, v0, fg, bg, oog, 1'b0);
      push_vertex(x1, y0, u1, v0, fg, bg, oog, 1'b0);
      push_vertex(x0, y1, u0, v1, fg, bg, oog, 1'b0);
      push_vertex(x0, y1, u0, v1, fg, bg, oog, 1'b0);
      push_vertex(x1, y0, u1, v0, fg, bg, oog, 1'b0);
      push_vertex(x1, y1, u1, v1, fg, bg, oog, 1'b1);
      pen_x = x1;
    end
  endtask

  // offer one word, wait for the handshake, then maybe idle between bursts
  task automatic send_word(input logic first, input logic [7:0] code,
                           input logic [7:0] scol, input logic [7:0] srow,
                           input logic [31:0] fg, input logic [31:0] bg);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= {bg, fg, srow, scol, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_glyph_vertices(first, code, scol, srow, fg, bg);
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  // program all four registers once the block has gone quiet
  task automatic write_glyph_regs(input logic [7:0] w, input logic [7:0] h,
                                  input logic [8:0] c, input logic [8:0] r);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= gqvg_pkg::RegGlyphWidth;
    cfg_wdata_i <= {1'b0, w};
    @(posedge clk_i);
    cfg_idx_i <= gqvg_pkg::RegGlyphHeight;
    cfg_wdata_i <= {1'b0, h};
    @(posedge clk_i);
    cfg_idx_i <= gqvg_pkg::RegGridColumns;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_idx_i <= gqvg_pkg::RegGridRows;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    glyph_w = w;
    glyph_h = h;
    atlas_cols = c;
    atlas_rows = r;
  endtask

  // newline, escapes, swallowed bytes and byte extremes at reset settings
  task automatic test_control_bytes();
    send_word(1'b1, 8'd65, 8'd0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(1'b0, 8'd0, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(1'b0, 8'd255, 8'd0, 8'd0, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    send_word(1'b0, gqvg_pkg::ChNewline, 8'd0, 8'd0, 32'h1, 32'h2);
    send_word(1'b0, gqvg_pkg::ChBackslash, 8'd0, 8'd0, 32'h3, 32'h4);
    send_word(1'b0, gqvg_pkg::ChLetterN, 8'd0, 8'd0, 32'h5, 32'h6);
    send_word(1'b0, gqvg_pkg::ChBackslash, 8'd0, 8'd0, 32'h7, 32'h8);
    send_word(1'b0, 8'd113, 8'd0, 8'd0, 32'h9, 32'hA);
    send_word(1'b0, gqvg_pkg::ChBackslash, 8'd0, 8'd0, 32'hB, 32'hC);
    send_word(1'b0, gqvg_pkg::ChBackslash, 8'd0, 8'd0, 32'hD, 32'hE);
    send_word(1'b0, 8'd90, 8'd0, 8'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    // a new text clears a dangling escape
    send_word(1'b0, gqvg_pkg::ChBackslash, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b1, 8'd66, 8'd3, 8'd2, 32'h1234_5678, 32'h8765_4321);
  endtask

  // zero registers: atlas counts act as one, glyph size stays zero
  task automatic test_zero_sizes();
    write_glyph_regs(8'd0, 8'd0, 9'd0, 9'd0);
    send_word(1'b1, 8'd200, 8'd5, 8'd7, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_word(1'b0, 8'd3, 8'd0, 8'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
  endtask

  // pen clamping at the far corner and rows past the atlas
  task automatic test_saturation();
    write_glyph_regs(8'd255, 8'd255, 9'd3, 9'd2);
    send_word(1'b1, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(1'b0, 8'd1, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b0, 8'd2, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b0, 8'd120, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b0, gqvg_pkg::ChNewline, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b0, gqvg_pkg::ChNewline, 8'd0, 8'd0, 32'h0, 32'h0);
    send_word(1'b0, 8'd4, 8'd0, 8'd0, 32'h0, 32'h0);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    write_glyph_regs(gqvg_pkg::GlyphWidthRst, gqvg_pkg::GlyphHeightRst,
                     gqvg_pkg::GridColumnsRst, gqvg_pkg::GridRowsRst);
    tx_gaps_on = 1'b0;
    hold_reqs <= hold_reqs + 1;
    send_word(1'b1, 8'd33, 8'd1, 8'd1, $urandom, $urandom);
    repeat (9) send_word(1'b0, 8'($urandom_range(11, 91)), 8'd0, 8'd0, $urandom, $urandom);
    tx_gaps_on = 1'b1;
  endtask

  // random texts: mostly well-formed runs with escapes and newlines mixed in
  task automatic run_text_stream(input int unsigned n_words);
    int unsigned sent, len, pick;
    logic [7:0]  scol, srow, code;
    logic        first;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 1)) begin
        scol = 8'($urandom_range(0, 255));
        srow = 8'($urandom_range(0, 255));
      end else begin
        scol = 8'($urandom_range(0, 20));
        srow = 8'($urandom_range(0, 20));
      end
      first = 1'b1;
      len = $urandom_range(1, 14);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        if (pick < 8) begin
          code = gqvg_pkg::ChNewline;
        end else if (pick < 16) begin
          send_word(first, gqvg_pkg::ChBackslash, scol, srow, $urandom, $urandom);
          sent++;
          first = 1'b0;
          if (pick < 12) code = gqvg_pkg::ChLetterN;
        end else if (pick < 18 && k == len - 1) begin
          // dangling escape carried into the next text
          code = gqvg_pkg::ChBackslash;
        end
        send_word(first, code, scol, srow, $urandom, $urandom);
        sent++;
        first = 1'b0;
      end
    end
  endtask

  task automatic test_random_texts();
    write_glyph_regs(gqvg_pkg::GlyphWidthRst, gqvg_pkg::GlyphHeightRst,
                     gqvg_pkg::GridColumnsRst, gqvg_pkg::GridRowsRst);
    run_text_stream(115);
    write_glyph_regs(8'd255, 8'd255, 9'd256, 9'd256);
    run_text_stream(115);
    write_glyph_regs(8'd1, 8'd1, 9'd1, 9'd1);
    run_text_stream(115);
    write_glyph_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     9'($urandom_range(1, 256)), 9'($urandom_range(1, 16)));
    run_text_stream(115);
  endtask

  // receiver: rotating stall pattern, refreshed now and then, or a long hold
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_pat[0];
      if (pat_age == 0) begin
        pat_age <= 40;
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'hFFFF;
          1: stall_pat <= 16'($urandom) | 16'h0001;
          2: stall_pat <= 16'h5555;
          default: stall_pat <= 16'($urandom & $urandom) | 16'h0001;
        endcase
      end else begin
        pat_age <= pat_age - 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // compare each accepted vertex with the oldest expected one
  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tuser, m_axis_tdata[129:0]};
      if (exp_wr == exp_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected vertex: x=%0d y=%0d u=%0d v=%0d last=%0b oog=%0b",
                   got.x, got.y, got.u, got.v, got.last, got.oog);
      end else begin
        exp_v = exp_ring[exp_rd];
        exp_rd = exp_rd + 8'd1;
        if (got.x !== exp_v.x || got.y !== exp_v.y || got.u !== exp_v.u ||
            got.v !== exp_v.v || got.fg !== exp_v.fg || got.bg !== exp_v.bg ||
            got.last !== exp_v.last || got.oog !== exp_v.oog) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"vertex mismatch: exp x=%0d y=%0d u=%0d v=%0d fg=%h bg=%h last=%0b",
                      " oog=%0b | got x=%0d y=%0d u=%0d v=%0d fg=%h bg=%h last=%0b oog=%0b"},
                     exp_v.x, exp_v.y, exp_v.u, exp_v.v, exp_v.fg, exp_v.bg,
                     exp_v.last, exp_v.oog, got.x, got.y, got.u, got.v, got.fg,
                     got.bg, got.last, got.oog);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_control_bytes();
    test_zero_sizes();
    test_saturation();
    test_output_backpressure();
    test_random_texts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && exp_wr == exp_rd) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
